// File: design/spor_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spor_pkg;

    localparam int CoordW  = 32;
    localparam int RadW    = 24;
    localparam int PrioW   = 8;
    localparam int MarginW = 16;

    // Distances below the far limit have at most 26 magnitude bits.
    localparam int DistW   = 27;
    localparam int MagW    = 26;
    localparam int SqW     = 54;
    localparam int SqrtInW = 64;
    localparam int LenW    = 32;
    localparam int RsumW   = 25;
    localparam int AwayW   = 26;

    // Dividend is |d| * away * 32 + len/2, below 2^57.
    localparam int NumW    = 57;
    localparam int QuoW    = 57;

    localparam logic [15:0] MarginReset = 16'd7;

    typedef struct packed {
        logic signed [CoordW-1:0] a_center_x;
        logic signed [CoordW-1:0] a_center_y;
        logic signed [CoordW-1:0] a_center_z;
        logic [RadW-1:0]          a_radius;
        logic [PrioW-1:0]         a_priority;
        logic signed [CoordW-1:0] b_center_x;
        logic signed [CoordW-1:0] b_center_y;
        logic signed [CoordW-1:0] b_center_z;
        logic [RadW-1:0]          b_radius;
        logic [PrioW-1:0]         b_priority;
    } pair_t;

    typedef struct packed {
        logic                     overlap;
        logic                     moved_is_a;
        logic signed [CoordW-1:0] new_x;
        logic signed [CoordW-1:0] new_y;
        logic signed [CoordW-1:0] new_z;
        logic                     coincident;
        logic                     saturated;
    } result_t;

    // Per-item context carried alongside the arithmetic.
    typedef struct packed {
        logic                     overlap;
        logic                     push;
        logic                     moved_is_a;
        logic                     coincident;
        logic signed [CoordW-1:0] pri_x;
        logic signed [CoordW-1:0] pri_y;
        logic signed [CoordW-1:0] pri_z;
        logic signed [CoordW-1:0] sec_x;
        logic signed [CoordW-1:0] sec_y;
        logic signed [CoordW-1:0] sec_z;
        logic [2:0]               neg;
        logic [MagW-1:0]          mag_x;
        logic [MagW-1:0]          mag_y;
        logic [MagW-1:0]          mag_z;
        logic [AwayW-1:0]         away;
    } ctx_t;

endpackage

`default_nettype wire

// File: design/spor_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spor_in_if;
    logic              valid;
    logic              ready;
    spor_pkg::pair_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spor_out_if;
    logic              valid;
    logic              ready;
    spor_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/sphere_pair_overlap_resolve_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Payload
// pair_in    in         two spheres: centers, radii, priorities
// res_out    out        overlap, moved_is_a, new center, coincident, saturated
// cfg        in         separation_margin, write enable and data
//
// A pair can be taken every cycle while the output is not stalled.
// The 32-stage square root and the 57-stage divider set the depth.
// Reset clears every valid bit and sets the margin to 7.
// A stall at the output freezes the whole pipeline; the output register
// holds its result until the transfer, and in.ready falls with it.
module sphere_pair_overlap_resolve_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    spor_in_if.sink                            pair_in,
    spor_out_if.source                         res_out,
    input  wire logic                          cfg_we,
    input  wire logic [spor_pkg::MarginW-1:0]  cfg_wdata
);
    localparam int CW = spor_pkg::CoordW;
    localparam int MW = spor_pkg::MagW;

    logic [spor_pkg::MarginW-1:0] margin_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= spor_pkg::MarginReset;
        else if (cfg_we)
            margin_reg <= cfg_wdata;
    end

    // The pipeline moves when the output register is empty or being drained.
    logic en;
    assign en = !res_out.valid || res_out.ready;
    assign pair_in.ready = en;

    // Stage 1: select primary/secondary and form axis differences.
    logic                 s1_v_reg;
    logic                 s1_asec_reg;
    logic signed [CW-1:0] s1_p_reg [3];
    logic signed [CW-1:0] s1_s_reg [3];
    logic signed [CW:0]   s1_d_reg [3];
    logic [spor_pkg::RsumW-1:0] s1_rsum_reg;

    logic                 asec_next;
    logic signed [CW-1:0] ac [3];
    logic signed [CW-1:0] bc [3];
    assign ac[0] = pair_in.data.a_center_x;
    assign ac[1] = pair_in.data.a_center_y;
    assign ac[2] = pair_in.data.a_center_z;
    assign bc[0] = pair_in.data.b_center_x;
    assign bc[1] = pair_in.data.b_center_y;
    assign bc[2] = pair_in.data.b_center_z;
    assign asec_next = pair_in.data.a_priority < pair_in.data.b_priority;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= pair_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_asec_reg <= asec_next;
            s1_rsum_reg <= {1'b0, pair_in.data.a_radius} + {1'b0, pair_in.data.b_radius};
            for (int c = 0; c < 3; c++)
            begin
                s1_p_reg[c] <= asec_next ? bc[c] : ac[c];
                s1_s_reg[c] <= asec_next ? ac[c] : bc[c];
                s1_d_reg[c] <= asec_next ? (CW+1)'(ac[c]) - (CW+1)'(bc[c])
                                         : (CW+1)'(bc[c]) - (CW+1)'(ac[c]);
            end
        end
    end

    // Stage 2: magnitudes, far and coincident flags, squares, rsum^2, away.
    logic                 s2_v_reg;
    logic                 s2_far_reg;
    logic                 s2_same_reg;
    logic [2:0]           s2_neg_reg;
    logic [MW-1:0]        s2_mag_reg [3];
    logic [2*MW-1:0]      s2_sq_reg  [3];
    logic [2*spor_pkg::RsumW-1:0] s2_rr_reg;
    logic [spor_pkg::AwayW-1:0]   s2_away_reg;
    logic                 s2_asec_reg;
    logic signed [CW-1:0] s2_p_reg [3];
    logic signed [CW-1:0] s2_s_reg [3];

    logic [CW:0]   absd [3];
    logic [MW-1:0] m2   [3];
    logic          far2;
    always_comb
    begin
        far2 = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            absd[c] = s1_d_reg[c][CW] ? (CW+1)'(-s1_d_reg[c]) : s1_d_reg[c];
            if (absd[c] >= (CW+1)'(1 << MW))
                far2 = 1'b1;
            m2[c] = absd[c][MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_far_reg  <= far2;
            s2_same_reg <= (s1_d_reg[0] == '0) && (s1_d_reg[1] == '0) && (s1_d_reg[2] == '0);
            s2_rr_reg   <= s1_rsum_reg * s1_rsum_reg;
            s2_away_reg <= spor_pkg::AwayW'(s1_rsum_reg) + spor_pkg::AwayW'(margin_reg);
            s2_asec_reg <= s1_asec_reg;
            s2_p_reg    <= s1_p_reg;
            s2_s_reg    <= s1_s_reg;
            for (int c = 0; c < 3; c++)
            begin
                s2_neg_reg[c] <= s1_d_reg[c][CW];
                s2_mag_reg[c] <= m2[c];
                s2_sq_reg[c]  <= m2[c] * m2[c];
            end
        end
    end

    // Stage 3: sum of squares and overlap test.
    logic                 s3_v_reg;
    logic [spor_pkg::SqW-1:0] s3_sq_reg;
    spor_pkg::ctx_t       s3_ctx_reg;

    logic [spor_pkg::SqW-1:0] sum3;
    logic                 ovl3;
    assign sum3 = spor_pkg::SqW'(s2_sq_reg[0]) + spor_pkg::SqW'(s2_sq_reg[1])
                + spor_pkg::SqW'(s2_sq_reg[2]);
    assign ovl3 = !s2_far_reg && (sum3 < spor_pkg::SqW'(s2_rr_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sq_reg              <= sum3;
            s3_ctx_reg.overlap     <= ovl3;
            s3_ctx_reg.push        <= ovl3 && !s2_same_reg;
            s3_ctx_reg.moved_is_a  <= s2_asec_reg;
            s3_ctx_reg.coincident  <= s2_same_reg;
            s3_ctx_reg.pri_x       <= s2_p_reg[0];
            s3_ctx_reg.pri_y       <= s2_p_reg[1];
            s3_ctx_reg.pri_z       <= s2_p_reg[2];
            s3_ctx_reg.sec_x       <= s2_s_reg[0];
            s3_ctx_reg.sec_y       <= s2_s_reg[1];
            s3_ctx_reg.sec_z       <= s2_s_reg[2];
            s3_ctx_reg.neg         <= s2_neg_reg;
            s3_ctx_reg.mag_x       <= s2_mag_reg[0];
            s3_ctx_reg.mag_y       <= s2_mag_reg[1];
            s3_ctx_reg.mag_z       <= s2_mag_reg[2];
            s3_ctx_reg.away        <= s2_away_reg;
        end
    end

    // Square root of the squared length scaled by 2^10.
    logic                 sq_v;
    logic [spor_pkg::LenW-1:0] sq_len;
    spor_pkg::ctx_t       sq_ctx;

    spor_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .in_rad    ({s3_sq_reg, 10'b0}),
        .in_ctx    (s3_ctx_reg),
        .out_valid (sq_v),
        .out_root  (sq_len),
        .out_ctx   (sq_ctx)
    );

    // Stage 4: dividends |d| * away * 32 + len/2 for the three axes.
    logic                 s4_v_reg;
    logic [spor_pkg::NumW-1:0] s4_num_reg [3];
    logic [spor_pkg::LenW-1:0] s4_len_reg;
    spor_pkg::ctx_t       s4_ctx_reg;

    logic [MW-1:0] cm [3];
    logic [MW+spor_pkg::AwayW-1:0] prod4 [3];
    assign cm[0] = sq_ctx.mag_x;
    assign cm[1] = sq_ctx.mag_y;
    assign cm[2] = sq_ctx.mag_z;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            prod4[c] = (MW+spor_pkg::AwayW)'(cm[c]) * (MW+spor_pkg::AwayW)'(sq_ctx.away);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= sq_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A zero length only occurs for coincident or non-overlapping
            // items, whose quotient is unused; force 1 to keep it defined.
            s4_len_reg <= (sq_len == '0) ? spor_pkg::LenW'(1) : sq_len;
            s4_ctx_reg <= sq_ctx;
            for (int c = 0; c < 3; c++)
                s4_num_reg[c] <= {prod4[c], 5'b0} + spor_pkg::NumW'(sq_len >> 1);
        end
    end

    logic                 dv_v;
    logic [spor_pkg::QuoW-1:0] dv_q [3];
    spor_pkg::ctx_t       dv_ctx;

    spor_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_v_reg),
        .in_num    (s4_num_reg),
        .in_den    (s4_len_reg),
        .in_ctx    (s4_ctx_reg),
        .out_valid (dv_v),
        .out_quo   (dv_q),
        .out_ctx   (dv_ctx)
    );

    // Final stage: apply signed offset, clamp, form the result.
    logic signed [CW-1:0] pri [3];
    logic signed [CW-1:0] sec [3];
    logic signed [spor_pkg::QuoW+1:0] sum_f [3];
    logic signed [CW-1:0] nc  [3];
    logic                 sat;
    assign pri[0] = dv_ctx.pri_x;
    assign pri[1] = dv_ctx.pri_y;
    assign pri[2] = dv_ctx.pri_z;
    assign sec[0] = dv_ctx.sec_x;
    assign sec[1] = dv_ctx.sec_y;
    assign sec[2] = dv_ctx.sec_z;

    always_comb
    begin
        sat = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            sum_f[c] = dv_ctx.neg[c]
                ? (spor_pkg::QuoW+2)'(pri[c]) - $signed({2'b00, dv_q[c]})
                : (spor_pkg::QuoW+2)'(pri[c]) + $signed({2'b00, dv_q[c]});
            nc[c] = sec[c];
            if (dv_ctx.push)
            begin
                if (sum_f[c] > (spor_pkg::QuoW+2)'(64'sd2147483647))
                begin
                    nc[c] = 32'sh7fffffff;
                    sat   = 1'b1;
                end
                else if (sum_f[c] < -(spor_pkg::QuoW+2)'(64'sd2147483648))
                begin
                    nc[c] = 32'sh80000000;
                    sat   = 1'b1;
                end
                else
                    nc[c] = sum_f[c][CW-1:0];
            end
        end
    end

    logic out_valid_reg;
    spor_pkg::result_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.overlap    <= dv_ctx.overlap;
            out_data_reg.moved_is_a <= dv_ctx.moved_is_a;
            out_data_reg.new_x      <= nc[0];
            out_data_reg.new_y      <= nc[1];
            out_data_reg.new_z      <= nc[2];
            out_data_reg.coincident <= dv_ctx.coincident;
            out_data_reg.saturated  <= sat;
        end
    end

    assign res_out.valid = out_valid_reg;
    assign res_out.data  = out_data_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.data))
        else $error("result changed during stall");
    a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
        pair_in.ready == (!res_out.valid || res_out.ready))
        else $error("input ready does not follow output space");
    a_sat_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.data.saturated |-> res_out.data.overlap
            && !res_out.data.coincident)
        else $error("saturation without a push");

endmodule

`default_nettype wire

// File: design/spor_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage, with a context
// word carried along. Advances when en is high.
module spor_isqrt (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [spor_pkg::SqrtInW-1:0]      in_rad,
    input  wire spor_pkg::ctx_t                    in_ctx,
    output logic                                   out_valid,
    output logic [spor_pkg::LenW-1:0]              out_root,
    output spor_pkg::ctx_t                         out_ctx
);
    localparam int N  = spor_pkg::LenW;
    localparam int RW = spor_pkg::SqrtInW;

    logic [N:0]        vld_reg;
    logic [RW-1:0]     rad_reg  [N+1];
    logic [N+1:0]      rem_reg  [N+1];
    logic [N-1:0]      root_reg [N+1];
    spor_pkg::ctx_t    ctx_reg  [N+1];

    always_comb
    begin
        vld_reg[0]  = in_valid;
        rad_reg[0]  = in_rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        ctx_reg[0]  = in_ctx;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N+1:0] rem_next;
        logic [N+1:0] trial;
        logic [N-1:0] root_next;

        always_comb
        begin
            rem_next  = {rem_reg[k][N-1:0], rad_reg[k][RW-1 -: 2]};
            trial     = {root_reg[k], 2'b01};
            root_next = {root_reg[k][N-2:0], 1'b0};
            if (rem_next >= trial)
            begin
                rem_next  = rem_next - trial;
                root_next = {root_reg[k][N-2:0], 1'b1};
            end
        end

        logic              v_r;
        logic [RW-1:0]     rad_r;
        logic [N+1:0]      rem_r;
        logic [N-1:0]      root_r;
        spor_pkg::ctx_t    ctx_r;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_r <= 1'b0;
            else if (en)
                v_r <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_r  <= {rad_reg[k][RW-3:0], 2'b00};
                rem_r  <= rem_next;
                root_r <= root_next;
                ctx_r  <= ctx_reg[k];
            end
        end

        always_comb
        begin
            vld_reg[k+1]  = v_r;
            rad_reg[k+1]  = rad_r;
            rem_reg[k+1]  = rem_r;
            root_reg[k+1] = root_r;
            ctx_reg[k+1]  = ctx_r;
        end
    end

    assign out_valid = vld_reg[N];
    assign out_root  = root_reg[N];
    assign out_ctx   = ctx_reg[N];

endmodule

`default_nettype wire

// File: design/spor_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider for three dividends sharing one divisor,
// one quotient bit per stage. Context rides along.
module spor_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [spor_pkg::NumW-1:0]     in_num [3],
    input  wire logic [spor_pkg::LenW-1:0]     in_den,
    input  wire spor_pkg::ctx_t                in_ctx,
    output logic                               out_valid,
    output logic [spor_pkg::QuoW-1:0]          out_quo [3],
    output spor_pkg::ctx_t                     out_ctx
);
    localparam int NW = spor_pkg::NumW;
    localparam int DW = spor_pkg::LenW;

    logic [NW:0]       vld_reg;
    logic [NW-1:0]     num_reg [NW+1][3];
    logic [DW:0]       rem_reg [NW+1][3];
    logic [DW-1:0]     den_reg [NW+1];
    spor_pkg::ctx_t    ctx_reg [NW+1];

    always_comb
    begin
        vld_reg[0] = in_valid;
        den_reg[0] = in_den;
        ctx_reg[0] = in_ctx;
        for (int c = 0; c < 3; c++)
        begin
            num_reg[0][c] = in_num[c];
            rem_reg[0][c] = '0;
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW+1:0]     sh   [3];
        logic [NW-1:0]     nn   [3];
        logic [DW:0]       rn   [3];
        logic              v_r;
        logic [NW-1:0]     num_r [3];
        logic [DW:0]       rem_r [3];
        logic [DW-1:0]     den_r;
        spor_pkg::ctx_t    ctx_r;

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                sh[c] = {rem_reg[k][c], num_reg[k][c][NW-1]};
                nn[c] = {num_reg[k][c][NW-2:0], 1'b0};
                if (sh[c] >= {2'b00, den_reg[k]})
                begin
                    rn[c] = DW'(sh[c] - {2'b00, den_reg[k]}) | (DW+1)'(0);
                    nn[c][0] = 1'b1;
                end
                else
                    rn[c] = sh[c][DW:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_r <= 1'b0;
            else if (en)
                v_r <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_r <= nn;
                rem_r <= rn;
                den_r <= den_reg[k];
                ctx_r <= ctx_reg[k];
            end
        end

        always_comb
        begin
            vld_reg[k+1] = v_r;
            num_reg[k+1] = num_r;
            rem_reg[k+1] = rem_r;
            den_reg[k+1] = den_r;
            ctx_reg[k+1] = ctx_r;
        end
    end

    assign out_valid = vld_reg[NW];
    assign out_quo   = num_reg[NW];
    assign out_ctx   = ctx_reg[NW];

endmodule

`default_nettype wire
